// ===== sv/pf_pkg.sv =====
// Shared types, constants and helpers for the Playfair stream encipher core.
// No dependencies; every other file of the block imports this package.

package pf_pkg;

  localparam int SQ_SIZE = 5;
  localparam int CELL_W  = 5;
  localparam int ROW_W   = SQ_SIZE * CELL_W;
  localparam int IDX_W   = 3;
  localparam int CHAR_W  = 8;
  localparam int CIPH_W  = 7;
  localparam int NUM_LET = 26;
  localparam int PF_QUEUE_DEPTH = 2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_ROW_0 = 3'd0;
  localparam logic [2:0] CFG_ROW_1 = 3'd1;
  localparam logic [2:0] CFG_ROW_2 = 3'd2;
  localparam logic [2:0] CFG_ROW_3 = 3'd3;
  localparam logic [2:0] CFG_ROW_4 = 3'd4;

  localparam logic [CELL_W-1:0] LET_X = 5'd23;
  localparam logic [CELL_W-1:0] LET_Z = 5'd25;

  localparam logic [CHAR_W-1:0] ASC_UA = 8'd65;   // 'A'
  localparam logic [CHAR_W-1:0] ASC_UZ = 8'd90;   // 'Z'
  localparam logic [CHAR_W-1:0] ASC_LA = 8'd97;   // 'a'
  localparam logic [CHAR_W-1:0] ASC_LZ = 8'd122;  // 'z'
  localparam logic [CHAR_W-1:0] ASC_CASE = ASC_LA - ASC_UA;

  // Key square: [row][column][letter bits]; a row is one 25-bit register.
  typedef logic [SQ_SIZE-1:0][SQ_SIZE-1:0][CELL_W-1:0] pf_square_t;

  // Reset square: A..Y (every letter but Z), row-major.
  localparam pf_square_t SQ_RESET = {25'd25942708, 25'd20530703, 25'd15118698,
                                     25'd9706693,  25'd4294688};

  // One pair of folded letters waiting to be enciphered.
  typedef struct packed {
    logic [CELL_W-1:0] a;
    logic [CELL_W-1:0] b;
    logic              pass;  // filler-filler pair, copied through unchanged
    logic              last;
  } pf_pair_t;

  typedef struct packed {
    logic full;
    logic empty;
  } pf_q_stat_t;

  // Letter index to ASCII upper case; out-of-range cells read as Z.
  function automatic logic [CIPH_W-1:0] pf_ascii(input logic [CELL_W-1:0] v);
    logic [CELL_W-1:0] c;
    c = (v > LET_Z) ? LET_Z : v;
    return ASC_UA[CIPH_W-1:0] + {{(CIPH_W-CELL_W){1'b0}}, c};
  endfunction

endpackage

// ===== sv/pf_stream_if.sv =====
// Valid/ready stream interfaces for the plaintext and ciphertext channels.
// Depends on pf_pkg for the field widths.

interface pf_in_if import pf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_in;
  logic              last_in;

  modport source (output valid, char_in, last_in, input ready);
  modport sink   (input valid, char_in, last_in, output ready);
endinterface

interface pf_out_if import pf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CIPH_W-1:0] cipher_char;
  logic              last_out;

  modport source (output valid, cipher_char, last_out, input ready);
  modport sink   (input valid, cipher_char, last_out, output ready);
endinterface

// ===== sv/pf_front.sv =====
// Front end: folds each plaintext byte to a letter index and forms pairs.
// Depends on pf_pkg and pf_in_if.

module pf_front import pf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  pf_in_if.sink      in_ch,
  input  pf_square_t sq,
  input  pf_q_stat_t q_stat,
  output logic       push,
  output pf_pair_t   push_pair
);

  logic [CELL_W-1:0] held_r, held_nxt;
  logic              have_r, have_nxt;
  logic [NUM_LET-1:0] present;
  logic [CELL_W-1:0] fill, miss, letter, pa, pb;
  logic [CHAR_W-1:0] up;
  logic              accept;

  // Which letters sit somewhere in the square.
  always_comb begin
    present = '0;
    for (int v = 0; v < NUM_LET; v++) begin
      for (int r = 0; r < SQ_SIZE; r++) begin
        for (int c = 0; c < SQ_SIZE; c++) begin
          if (sq[r][c] == CELL_W'(v)) present[v] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    miss = LET_Z;
    for (int v = NUM_LET - 1; v >= 0; v--) begin
      if (!present[v]) miss = CELL_W'(v);
    end
  end

  assign fill = present[LET_X] ? LET_X : LET_Z;

  always_comb begin
    up = in_ch.char_in;
    if (up >= ASC_LA && up <= ASC_LZ) up = up - ASC_CASE;
    if (up < ASC_UA || up > ASC_UZ) begin
      letter = fill;
    end else begin
      letter = CELL_W'(up - ASC_UA);
      if (letter == miss) letter = fill;
    end
  end

  assign in_ch.ready = !q_stat.full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign push        = accept && (have_r || in_ch.last_in);

  // A lone last letter pairs with the filler; a doubled letter takes the filler.
  always_comb begin
    pa = have_r ? held_r : letter;
    pb = have_r ? letter : fill;
    push_pair.a    = pa;
    push_pair.pass = (pa == pb) && (pa == fill);
    push_pair.b    = (pa == pb) ? fill : pb;
    push_pair.last = in_ch.last_in;
  end

  always_comb begin
    held_nxt = held_r;
    have_nxt = have_r;
    if (accept) begin
      if (have_r || in_ch.last_in) begin
        have_nxt = 1'b0;
      end else begin
        have_nxt = 1'b1;
        held_nxt = letter;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
      held_r <= '0;
    end else begin
      have_r <= have_nxt;
      held_r <= held_nxt;
    end
  end

endmodule

// ===== sv/pf_pair_fifo.sv =====
// Short queue of letter pairs between the front and back ends.
// Depends on pf_pkg.

module pf_pair_fifo import pf_pkg::*; #(
  parameter int DEPTH = PF_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  pf_pair_t   push_pair,
  input  logic       pop,
  output pf_pair_t   head,
  output pf_q_stat_t q_stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pf_pair_t mem [DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign head         = mem[rd_r];
  assign q_stat.full  = (cnt_r == CNT_W'(DEPTH));
  assign q_stat.empty = (cnt_r == '0);

  always_comb begin
    wr_nxt  = push ? bump(wr_r) : wr_r;
    rd_nxt  = pop ? bump(rd_r) : rd_r;
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (!push && pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_r] <= push_pair;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== sv/pf_back.sv =====
// Back end: locates a pair in the key square and sends two cipher letters.
// Depends on pf_pkg and pf_out_if.

module pf_back import pf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  pf_square_t sq,
  input  pf_pair_t   head,
  input  pf_q_stat_t q_stat,
  output logic       pop,
  pf_out_if.source   out_ch
);

  logic              busy_r, busy_nxt, second_r, second_nxt, last_r, last_nxt;
  logic [CIPH_W-1:0] l0_r, l0_nxt, l1_r, l1_nxt, c0, c1;
  logic [IDX_W-1:0]  ra, ca, rb, cb, oa_r, oa_c, ob_r, ob_c;
  logic              beat;

  // First cell in row-major order that holds v; row 0, column 0 if none.
  function automatic logic [2*IDX_W-1:0] find(input pf_square_t s,
                                              input logic [CELL_W-1:0] v);
    logic [IDX_W-1:0] rr, cc;
    rr = '0;
    cc = '0;
    for (int r = SQ_SIZE - 1; r >= 0; r--) begin
      for (int c = SQ_SIZE - 1; c >= 0; c--) begin
        if (s[r][c] == v) begin
          rr = IDX_W'(r);
          cc = IDX_W'(c);
        end
      end
    end
    return {rr, cc};
  endfunction

  function automatic logic [IDX_W-1:0] inc5(input logic [IDX_W-1:0] x);
    return (x == IDX_W'(SQ_SIZE - 1)) ? '0 : x + 1'b1;
  endfunction

  always_comb begin
    {ra, ca} = find(sq, head.a);
    {rb, cb} = find(sq, head.b);
    oa_r = ra;
    oa_c = ca;
    ob_r = rb;
    ob_c = cb;
    if (ca == cb) begin
      oa_r = inc5(ra);
      ob_r = inc5(rb);
    end else if (ra == rb) begin
      oa_c = inc5(ca);
      ob_c = inc5(cb);
    end else begin
      oa_c = cb;
      ob_c = ca;
    end
    if (head.pass) begin
      c0 = pf_ascii(head.a);
      c1 = pf_ascii(head.b);
    end else begin
      c0 = pf_ascii(sq[oa_r][oa_c]);
      c1 = pf_ascii(sq[ob_r][ob_c]);
    end
  end

  assign beat = busy_r && out_ch.ready;
  assign pop  = !q_stat.empty && (!busy_r || (second_r && out_ch.ready));

  assign out_ch.valid       = busy_r;
  assign out_ch.cipher_char = second_r ? l1_r : l0_r;
  assign out_ch.last_out    = second_r && last_r;

  always_comb begin
    busy_nxt   = busy_r;
    second_nxt = second_r;
    l0_nxt     = l0_r;
    l1_nxt     = l1_r;
    last_nxt   = last_r;
    if (beat && !second_r) begin
      second_nxt = 1'b1;
    end else if (beat) begin
      busy_nxt = 1'b0;
    end
    if (pop) begin
      busy_nxt   = 1'b1;
      second_nxt = 1'b0;
      l0_nxt     = c0;
      l1_nxt     = c1;
      last_nxt   = head.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      second_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      second_r <= second_nxt;
    end
    l0_r   <= l0_nxt;
    l1_r   <= l1_nxt;
    last_r <= last_nxt;
  end

endmodule

// ===== sv/playfair_stream_encipher_core.sv =====
// Top level of the Playfair stream encipher core: key square registers,
// front end, pair queue and back end. Depends on every other file.

// The core enciphers a byte stream with a 5x5 Playfair key square held in
// five 25-bit row registers (column 0 in the low bits). The input channel
// takes one plaintext byte per beat and can accept a beat in every cycle
// while the pair queue has room. Every second input beat, or an input beat
// marked last, completes a pair, and each pair leaves as two output beats,
// so the sustained rate is one input beat per cycle while the output is
// ready, set by the back end sending one cipher letter per cycle. A pair
// passes through the queue and the output register before its first cipher
// letter leaves. The queue lets the output side stall while the input keeps
// filling it. Lower case is folded to upper case; non-letters and the one
// letter missing from the square become the filler (X, or Z when X is not
// in the square). A doubled letter has its second letter replaced by the
// filler, and a filler-filler pair is sent through unchanged. An odd final
// character is padded with the filler, and the last cipher letter of a
// message carries last_out. Write the row registers only while the core is
// idle; a letter already held waiting for its partner keeps the folding in
// force when it arrived.

module playfair_stream_encipher_core import pf_pkg::*; #(
  parameter int QUEUE_DEPTH = PF_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  pf_in_if.sink            in_ch,
  pf_out_if.source         out_ch,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [ROW_W-1:0] cfg_wdata
);

  pf_square_t sq_r, sq_nxt;
  pf_pair_t   push_pair, head;
  pf_q_stat_t q_stat;
  logic       push, pop;

  // Key square registers; writes to indexes past the last row are dropped.
  always_comb begin
    sq_nxt = sq_r;
    if (cfg_we && cfg_index <= CFG_ROW_4) begin
      sq_nxt[cfg_index] = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_r <= SQ_RESET;
    end else begin
      sq_r <= sq_nxt;
    end
  end

  pf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .sq        (sq_r),
    .q_stat    (q_stat),
    .push      (push),
    .push_pair (push_pair)
  );

  pf_pair_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_pair (push_pair),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  pf_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .sq     (sq_r),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule
